[hdl/hsl2rgb_pkg.sv]
// Shared definitions for the HSL/HSV to RGB converter.
// Holds the default fraction width and the hue sector codes; no dependencies.
`default_nettype none

package hsl2rgb_pkg;

  localparam int FRAC_BITS_DEF = 16;

  // Sixth of the hue circle, in order of increasing hue.
  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

endpackage

`default_nettype wire

[hdl/hsl2rgb_mul_round.sv]
// Unsigned fixed point multiply with round to nearest, half up: (a*b + 1/2) >> FRAC_BITS.
// Both operands and the result lie in 0..1.0. Uses hsl2rgb_pkg for the default width.
`default_nettype none

module hsl2rgb_mul_round #(
  parameter int FRAC_BITS = hsl2rgb_pkg::FRAC_BITS_DEF
) (
  input  wire logic [FRAC_BITS:0] a,
  input  wire logic [FRAC_BITS:0] b,
  output logic      [FRAC_BITS:0] p
);

  localparam int PROD_W = 2 * FRAC_BITS + 2;
  localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_BITS - 1);

  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] rounded;

  assign prod    = PROD_W'(a) * PROD_W'(b);
  assign rounded = prod + HALF;
  // Operands are at most 1.0, so the result fits in FRAC_BITS+1 bits.
  assign p       = rounded[2*FRAC_BITS:FRAC_BITS];

endmodule

`default_nettype wire

[hdl/hsl_hsv_to_rgb_unit.sv]
// Top level of the HSL/HSV to RGB converter: four-stage pipeline with stream ports.
// Depends on hsl2rgb_pkg and hsl2rgb_mul_round.
`default_nettype none

// Converts one pixel per clock from HSL (in_tuser = 0) or HSV (in_tuser = 1) to RGB.
// Hue is a fraction of a full turn, saturation and lightness/value are signed fixed
// point clamped to 0..1.0, and red, green and blue come out as unsigned fixed point
// with FRAC_BITS fraction bits. Each transaction passes through the stage 1, 2, 3 and
// output registers in turn; a new transaction is taken every cycle while the output side
// keeps up. The pipeline advances as one: any stall at out_tready holds every stage, and
// in_tready follows the output register being free or being drained that cycle.
// The two rounding multiplies (chroma, then the secondary component) set the
// stage depth.
module hsl_hsv_to_rgb_unit #(
  parameter int FRAC_BITS = hsl2rgb_pkg::FRAC_BITS_DEF,
  localparam int IN_W       = 3 * FRAC_BITS + 4,
  localparam int IN_TDATA_W = ((IN_W + 7) / 8) * 8,
  localparam int OUT_W      = 3 * (FRAC_BITS + 1),
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,

  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // hue_turn, saturation, level (lowest bit first), zero padded
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // action: 0 = HSL, 1 = HSV
  input  wire logic                   in_tuser,

  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // red, green, blue (lowest bit first), zero padded
  output logic [OUT_TDATA_W-1:0]      out_tdata
);

  localparam int VW   = FRAC_BITS + 1;   // unit-range value width
  localparam int SLW  = FRAC_BITS + 2;   // signed input width
  localparam int H6_W = FRAC_BITS + 3;
  localparam logic [VW-1:0] ONE = VW'(1) << FRAC_BITS;

  logic ce;

  // ---------------- stage 1: clamp, hue sector, chroma base ----------------
  logic [FRAC_BITS-1:0] hue;
  logic [SLW-1:0]       sat_raw, lev_raw;
  logic [H6_W-1:0]      h6;
  logic [FRAC_BITS-1:0] frac;
  logic [SLW-1:0]       two_l, one_w, lev_dist;

  logic                 v1_r;
  logic                 hsv1_r, hsv1_nxt;
  hsl2rgb_pkg::sector_t sec1_r, sec1_nxt;
  logic [VW-1:0]        tri1_r, tri1_nxt;
  logic [VW-1:0]        sat1_r, sat1_nxt;
  logic [VW-1:0]        lev1_r, lev1_nxt;
  logic [VW-1:0]        base1_r, base1_nxt;

  assign hue     = in_tdata[FRAC_BITS-1:0];
  assign sat_raw = in_tdata[FRAC_BITS+SLW-1:FRAC_BITS];
  assign lev_raw = in_tdata[FRAC_BITS+2*SLW-1:FRAC_BITS+SLW];
  assign one_w   = SLW'(ONE);

  always_comb begin
    hsv1_nxt = in_tuser;
    if (sat_raw[SLW-1]) begin
      sat1_nxt = '0;
    end else if (sat_raw > one_w) begin
      sat1_nxt = ONE;
    end else begin
      sat1_nxt = sat_raw[VW-1:0];
    end
    if (lev_raw[SLW-1]) begin
      lev1_nxt = '0;
    end else if (lev_raw > one_w) begin
      lev1_nxt = ONE;
    end else begin
      lev1_nxt = lev_raw[VW-1:0];
    end

    h6       = H6_W'({hue, 2'b00}) + H6_W'({hue, 1'b0});
    sec1_nxt = hsl2rgb_pkg::sector_t'(h6[H6_W-1:FRAC_BITS]);
    frac     = h6[FRAC_BITS-1:0];
    tri1_nxt = h6[FRAC_BITS] ? (ONE - VW'(frac)) : VW'(frac);

    two_l    = {lev1_nxt, 1'b0};
    lev_dist = (two_l >= one_w) ? (two_l - one_w) : (one_w - two_l);
    base1_nxt = in_tuser ? lev1_nxt : (ONE - lev_dist[VW-1:0]);
  end

  // ---------------- stage 2: chroma ----------------
  logic [VW-1:0]        c_prod;
  logic                 v2_r;
  logic                 hsv2_r;
  hsl2rgb_pkg::sector_t sec2_r;
  logic [VW-1:0]        tri2_r, lev2_r;
  logic [VW-1:0]        c2_r, c2_nxt;

  hsl2rgb_mul_round #(.FRAC_BITS(FRAC_BITS)) u_mul_chroma (
    .a(base1_r),
    .b(sat1_r),
    .p(c_prod)
  );
  assign c2_nxt = c_prod;

  // ---------------- stage 3: secondary component and offset ----------------
  logic [VW-1:0]        x_prod;
  logic                 v3_r;
  hsl2rgb_pkg::sector_t sec3_r;
  logic [VW-1:0]        c3_r;
  logic [VW-1:0]        x3_r, x3_nxt;
  logic [VW-1:0]        m3_r, m3_nxt;

  hsl2rgb_mul_round #(.FRAC_BITS(FRAC_BITS)) u_mul_second (
    .a(c2_r),
    .b(tri2_r),
    .p(x_prod)
  );

  always_comb begin
    x3_nxt = x_prod;
    // HSL keeps half the chroma below the lightness, HSV puts it all below the value
    m3_nxt = hsv2_r ? (lev2_r - c2_r) : (lev2_r - (c2_r >> 1));
  end

  // ---------------- stage 4: sector mix and offset ----------------
  logic [VW-1:0] r_pre, g_pre, b_pre;
  logic [VW:0]   r_sum, g_sum, b_sum;
  logic [VW-1:0] red_r, red_nxt;
  logic [VW-1:0] green_r, green_nxt;
  logic [VW-1:0] blue_r, blue_nxt;
  logic          out_valid_r;

  always_comb begin
    unique case (sec3_r)
      hsl2rgb_pkg::SEC_RED_YEL: begin r_pre = c3_r; g_pre = x3_r; b_pre = '0;   end
      hsl2rgb_pkg::SEC_YEL_GRN: begin r_pre = x3_r; g_pre = c3_r; b_pre = '0;   end
      hsl2rgb_pkg::SEC_GRN_CYN: begin r_pre = '0;   g_pre = c3_r; b_pre = x3_r; end
      hsl2rgb_pkg::SEC_CYN_BLU: begin r_pre = '0;   g_pre = x3_r; b_pre = c3_r; end
      hsl2rgb_pkg::SEC_BLU_MAG: begin r_pre = x3_r; g_pre = '0;   b_pre = c3_r; end
      default:                  begin r_pre = c3_r; g_pre = '0;   b_pre = x3_r; end
    endcase
    r_sum = (VW+1)'(r_pre) + (VW+1)'(m3_r);
    g_sum = (VW+1)'(g_pre) + (VW+1)'(m3_r);
    b_sum = (VW+1)'(b_pre) + (VW+1)'(m3_r);
    red_nxt   = (r_sum > (VW+1)'(ONE)) ? ONE : r_sum[VW-1:0];
    green_nxt = (g_sum > (VW+1)'(ONE)) ? ONE : g_sum[VW-1:0];
    blue_nxt  = (b_sum > (VW+1)'(ONE)) ? ONE : b_sum[VW-1:0];
  end

  // ---------------- pipeline control ----------------
  // whole pipe moves together; empty output register or a draining one frees it
  assign ce        = !out_valid_r || out_tready;
  assign in_tready = ce;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (ce) begin
      v1_r        <= in_tvalid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      hsv1_r  <= hsv1_nxt;
      sec1_r  <= sec1_nxt;
      tri1_r  <= tri1_nxt;
      sat1_r  <= sat1_nxt;
      lev1_r  <= lev1_nxt;
      base1_r <= base1_nxt;

      hsv2_r  <= hsv1_r;
      sec2_r  <= sec1_r;
      tri2_r  <= tri1_r;
      lev2_r  <= lev1_r;
      c2_r    <= c2_nxt;

      sec3_r  <= sec2_r;
      c3_r    <= c2_r;
      x3_r    <= x3_nxt;
      m3_r    <= m3_nxt;

      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({blue_r, green_r, red_r});

  // ---------------- checks ----------------
  a_second_below_chroma: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> (x3_r <= c3_r))
    else $error("secondary component exceeds chroma");

  a_peak_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> ((VW+1)'(m3_r) + (VW+1)'(c3_r) <= (VW+1)'(ONE)))
    else $error("offset plus chroma exceeds full scale");

  a_out_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (red_r <= ONE && green_r <= ONE && blue_r <= ONE))
    else $error("output component above full scale");

  a_valid_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (ce && v2_r) |=> v3_r)
    else $error("transaction dropped between stages");

endmodule

`default_nettype wire

[bench/tb_top.sv]
// Self-checking bench for hsl_hsv_to_rgb_unit: stream stimulus and result checks.
// Predicts each RGB pixel in-bench from the HSL/HSV formulas; depends on hsl2rgb_pkg.

module tb_top;

  localparam int FB          = hsl2rgb_pkg::FRAC_BITS_DEF;
  localparam int SL_W        = FB + 2;
  localparam int CH_W        = FB + 1;
  localparam int IN_TDATA_W  = ((3 * FB + 4 + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((3 * CH_W + 7) / 8) * 8;
  localparam longint unsigned ONE  = 64'd1 << FB;
  localparam longint unsigned HALF = ONE >> 1;
  localparam int CYCLE_LIMIT = 400000;
  localparam int REPORT_MAX  = 10;

  localparam bit FMT_HSL = 1'b0;
  localparam bit FMT_HSV = 1'b1;

  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } rgb_t;

  // Holds the RGB pixels owed by the block, oldest first.
  class rgb_ledger;
    rgb_t due_q[$];
    int   mismatches;

    function longint unsigned unit_clamp(logic [SL_W-1:0] raw);
      if (raw[SL_W-1]) return 0;
      return (raw > ONE) ? ONE : longint'(raw);
    endfunction

    function longint unsigned mul_q(longint unsigned a, longint unsigned b);
      return (a * b + HALF) >> FB;
    endfunction

    function logic [CH_W-1:0] cap(longint unsigned v);
      return (v > ONE) ? ONE[CH_W-1:0] : v[CH_W-1:0];
    endfunction

    function rgb_t hsx_to_rgb(logic use_hsv, logic [FB-1:0] hue,
                              logic [SL_W-1:0] sat_raw, logic [SL_W-1:0] lev_raw);
      longint unsigned s, l, h6, frac, tri_w, c, m, x, dist_w, r, g, b;
      hsl2rgb_pkg::sector_t sec;
      rgb_t px;
      s     = unit_clamp(sat_raw);
      l     = unit_clamp(lev_raw);
      h6    = longint'(hue) * 6;
      sec   = hsl2rgb_pkg::sector_t'(h6 >> FB);
      frac  = h6 & (ONE - 1);
      tri_w = (h6 >> FB) % 2 ? ONE - frac : frac;
      if (use_hsv) begin
        c = mul_q(l, s);
        m = l - c;
      end else begin
        dist_w = (2 * l >= ONE) ? 2 * l - ONE : ONE - 2 * l;
        c = mul_q(ONE - dist_w, s);
        m = l - (c >> 1);
      end
      x = mul_q(c, tri_w);
      case (sec)
        hsl2rgb_pkg::SEC_RED_YEL: begin r = c; g = x; b = 0; end
        hsl2rgb_pkg::SEC_YEL_GRN: begin r = x; g = c; b = 0; end
        hsl2rgb_pkg::SEC_GRN_CYN: begin r = 0; g = c; b = x; end
        hsl2rgb_pkg::SEC_CYN_BLU: begin r = 0; g = x; b = c; end
        hsl2rgb_pkg::SEC_BLU_MAG: begin r = x; g = 0; b = c; end
        default: begin r = c; g = 0; b = x; end
      endcase
      px.red   = cap(r + m);
      px.green = cap(g + m);
      px.blue  = cap(b + m);
      return px;
    endfunction

    function void note_pixel(logic [IN_TDATA_W-1:0] tdata, logic tuser);
      due_q.push_back(hsx_to_rgb(tuser, tdata[FB-1:0], tdata[FB+SL_W-1:FB],
                                 tdata[FB+2*SL_W-1:FB+SL_W]));
    endfunction

    function void check_pixel(logic [OUT_TDATA_W-1:0] tdata);
      rgb_t got, want;
      got = tdata[3*CH_W-1:0];
      if (due_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected pixel r=%0d g=%0d b=%0d", got.red, got.green, got.blue);
        return;
      end
      want = due_q.pop_front();
      if (got !== want || tdata[OUT_TDATA_W-1:3*CH_W] !== '0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("pixel mismatch: want r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d pad=%0h",
                   want.red, want.green, want.blue, got.red, got.green, got.blue,
                   tdata[OUT_TDATA_W-1:3*CH_W]);
      end
    endfunction

    function int outstanding();
      return due_q.size();
    endfunction
  endclass

  bit clk;
  logic rst_n;
  logic in_tvalid, in_tuser, out_tready;
  logic [IN_TDATA_W-1:0] in_tdata;
  wire in_tready, out_tvalid;
  wire [OUT_TDATA_W-1:0] out_tdata;

  rgb_ledger pending = new();
  int tx_odds, rx_odds, rx_stall, cycles;

  hsl_hsv_to_rgb_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // Bus monitor: input transactions noted before results are checked.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) pending.note_pixel(in_tdata, in_tuser);
      if (out_tvalid && out_tready) pending.check_pixel(out_tdata);
    end
  end

  // Result side back-pressure, in bursts.
  always @(negedge clk) begin
    if (rx_stall > 0) begin
      rx_stall--;
      out_tready <= 1'b0;
    end else if (rx_odds != 0 && $urandom_range(0, rx_odds - 1) == 0) begin
      rx_stall = $urandom_range(0, 15);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic push_pixel(input logic act, input int hue, input int sat, input int lev);
    int gap;
    logic [IN_TDATA_W-1:0] word;
    if (tx_odds != 0 && $urandom_range(0, tx_odds - 1) == 0) begin
      gap = $urandom_range(1, 16);
      repeat (gap) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
      end
    end
    word = '0;
    word[FB-1:0] = hue[FB-1:0];
    word[FB+SL_W-1:FB] = sat[SL_W-1:0];
    word[FB+2*SL_W-1:FB+SL_W] = lev[SL_W-1:0];
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    in_tuser  <= act;
    do @(posedge clk); while (!in_tready);
  endtask

  // Saturation or level: mostly in range, sometimes anywhere in the field or an edge value.
  function automatic int pick_unit();
    case ($urandom_range(0, 9))
      0, 1: return $urandom_range(0, (1 << SL_W) - 1);
      2: begin
        case ($urandom_range(0, 5))
          0: return 0;
          1: return int'(ONE);
          2: return int'(ONE) + 1;
          3: return -1;
          4: return (1 << (SL_W - 1)) - 1;
          default: return -(1 << (SL_W - 1));
        endcase
      end
      default: return $urandom_range(0, int'(ONE));
    endcase
  endfunction

  // Hue: uniform, or close to a sector boundary.
  function automatic int pick_hue();
    int k;
    if ($urandom_range(0, 3) == 0) begin
      k = $urandom_range(0, 6);
      return (k * int'(ONE) / 6 + $urandom_range(0, 4) - 2) & int'(ONE - 1);
    end
    return $urandom_range(0, int'(ONE) - 1);
  endfunction

  task automatic random_run(input int count, input bit calm);
    for (int i = 0; i < count; i++) begin
      if (i % 150 == 0) begin
        tx_odds = calm ? 0 : (i % 300 == 0 ? 3 : 0);
        rx_odds = calm ? 0 : (i % 450 == 0 ? 0 : 4);
      end
      push_pixel($urandom_range(0, 1), pick_hue(), pick_unit(), pick_unit());
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    out_tready = 1'b0;
    tx_odds = 4;
    rx_odds = 4;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // primaries, sector edges, clamping in both directions
    push_pixel(FMT_HSL, 0, 65536, 32768);
    push_pixel(FMT_HSV, 0, 65536, 65536);
    push_pixel(FMT_HSL, 65535, 131071, 131071);
    push_pixel(FMT_HSV, 65535, -131072, -131072);
    push_pixel(FMT_HSL, 10922, 65536, 32768);
    push_pixel(FMT_HSV, 10923, 65536, 65536);
    push_pixel(FMT_HSL, 21845, 65536, 32768);
    push_pixel(FMT_HSV, 21846, 40000, 50000);
    push_pixel(FMT_HSL, 32768, 65536, 32768);
    push_pixel(FMT_HSV, 43690, 65536, 65536);
    push_pixel(FMT_HSL, 43691, 65536, 20000);
    push_pixel(FMT_HSV, 54613, 65536, 65536);
    push_pixel(FMT_HSL, 54614, 30000, 45000);
    push_pixel(FMT_HSL, 5461, 65537, -1);
    push_pixel(FMT_HSV, 16384, -1, 65537);
    push_pixel(FMT_HSL, 49152, 0, 65536);
    push_pixel(FMT_HSV, 27306, 65535, 65535);
    push_pixel(FMT_HSL, 38229, 1, 1);
    push_pixel(FMT_HSV, 60074, 65536, 0);
    push_pixel(FMT_HSL, 0, 0, 0);
    push_pixel(FMT_HSV, 32767, 131071, -131072);
    push_pixel(FMT_HSL, 12345, 65536, 65535);
    push_pixel(FMT_HSV, 1, 1, 131071);

    // let the pipeline empty completely before the random part
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending.outstanding() != 0) @(posedge clk);

    random_run(1650, 1'b0);
    random_run(300, 1'b1);
    @(negedge clk);
    in_tvalid <= 1'b0;

    while (pending.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (pending.mismatches == 0 && pending.outstanding() == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

endmodule

[hsl_hsv_to_rgb_unit.f]
hdl/hsl2rgb_pkg.sv
hdl/hsl2rgb_mul_round.sv
hdl/hsl_hsv_to_rgb_unit.sv
bench/tb_top.sv
